// ===== rtl/fwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fwbc_pkg
// Types and constants shared by the FIFO write-back cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none
package fwbc_pkg;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       write_back;
    logic       fill_read;
    logic       seen_full;
  } out_item_t;

  localparam logic [1:0] CFG_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_INDEX    = 2'd1;
  localparam logic [1:0] CFG_WAYS     = 2'd2;
  localparam logic [1:0] CFG_CLASSIFY = 2'd3;

  localparam logic [1:0] OUT_HIT        = 2'd0;
  localparam logic [1:0] OUT_MISS       = 2'd1;
  localparam logic [1:0] OUT_COMPULSORY = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/fwbc_seen.sv =====
// ----------------------------------------------------------------------------
// fwbc_seen
// Seen-before block table: sequential scan with one shared compare, append.
// ----------------------------------------------------------------------------
`default_nettype none
module fwbc_seen #(
  parameter int DEPTH = 4096,
  parameter int AW    = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [AW-1:0] block,
  output logic               done,
  output logic               is_new,
  output logic               full
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_CMP = 4'b0100, S_DONE = 4'b1000
  } st_t;

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_r;
  st_t           st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          new_r, new_nxt, full_r, full_nxt;
  logic          wr_en;

  always_ff @(posedge clk) begin
    rd_r <= mem[ptr_r[IW-1:0]];
    if (wr_en) begin
      mem[cnt_r[IW-1:0]] <= block;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    ptr_nxt  = ptr_r;
    new_nxt  = new_r;
    full_nxt = full_r;
    wr_en    = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          ptr_nxt = '0;
          st_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (ptr_r >= cnt_r) begin
          new_nxt = 1'b1;
          if (cnt_r < CW'(DEPTH)) begin
            wr_en    = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            full_nxt = 1'b0;
          end else begin
            full_nxt = 1'b1;
          end
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_r == block) begin
          new_nxt  = 1'b0;
          full_nxt = 1'b0;
          st_nxt   = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          st_nxt  = S_READ;
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    ptr_r  <= ptr_nxt;
    new_r  <= new_nxt;
    full_r <= full_nxt;
  end

  assign done   = (st_r == S_DONE);
  assign is_new = new_r;
  assign full   = full_r;
endmodule
`default_nettype wire

// ===== rtl/fifo_write_back_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// fifo_write_back_cache_lookup
// Set-associative write-back cache tag lookup with FIFO replacement.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset a clearing pass walks the line
// store, one set per cycle, before in_ready rises.
// A lookup reads the set row, then one shared tag comparator checks
// one way per cycle, up to ways_used ways, then updates and presents the
// result. A classified miss also scans the seen-before table, reading
// and then comparing one entry at a time.
`default_nettype none
module fifo_write_back_cache_lookup
  import fwbc_pkg::*;
#(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8,
  parameter int SEEN_DEPTH   = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_wdata
);
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW   = $clog2(MAX_WAYS + 1);
  localparam int LW    = 32 + 2;
  localparam int RW    = MAX_WAYS * LW + WW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_READ = 7'b0000100,
    S_CMP   = 7'b0001000, S_UPD  = 7'b0010000, S_SEEN = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  logic [3:0] offset_r, index_r, ways_r;
  logic       classify_r;

  logic [RW-1:0] mem [NSETS];
  logic [RW-1:0] row_r, row_nxt, rd_q;
  logic          mem_we;
  logic [SW-1:0] mem_addr;

  st_t           st_r, st_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] set_r, set_nxt;
  logic [31:0]   tag_r, tag_nxt, block_r, block_nxt;
  logic          op_r, op_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [WCW-1:0] ways_eff;
  out_item_t     res_r, res_nxt;
  logic          seen_start;
  logic          seen_done, seen_new, seen_fl;

  logic [31:0]  blk_c;
  logic [3:0]   ib_c;
  logic [31:0]  set_mask;
  logic [LW-1:0] line_c;
  logic [WW-1:0] ptr_c, vic_c, nxt_c;
  logic [LW-1:0] vline_c;

  always_comb begin
    if (ways_r == 4'd0) ways_eff = WCW'(1);
    else if (32'(ways_r) > MAX_WAYS) ways_eff = WCW'(MAX_WAYS);
    else ways_eff = WCW'(ways_r);
    ib_c = (32'(index_r) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : index_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= 4'd5;
      index_r    <= 4'd10;
      ways_r     <= 4'd1;
      classify_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET:   offset_r   <= cfg_wdata;
        CFG_INDEX:    index_r    <= cfg_wdata;
        CFG_WAYS:     ways_r     <= cfg_wdata;
        CFG_CLASSIFY: classify_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= row_nxt;
    end
    rd_q <= mem[mem_addr];
  end

  fwbc_seen #(.DEPTH(SEEN_DEPTH), .AW(32)) u_seen (
    .clk(clk), .rst_n(rst_n), .start(seen_start), .block(block_r),
    .done(seen_done), .is_new(seen_new), .full(seen_fl)
  );

  always_comb begin
    blk_c    = in_data.address >> offset_r;
    set_mask = (32'd1 << ib_c) - 32'd1;
    line_c   = row_r[32'(w_r) * LW +: LW];
    ptr_c    = row_r[RW-1 -: WW];
    vic_c    = (WCW'(ptr_c) >= ways_eff) ? '0 : ptr_c;
    nxt_c    = (WCW'(vic_c) + WCW'(1) >= ways_eff) ? '0 : WW'(WCW'(vic_c) + WCW'(1));
    vline_c  = row_r[32'(vic_c) * LW +: LW];
  end

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    set_nxt    = set_r;
    tag_nxt    = tag_r;
    block_nxt  = block_r;
    op_nxt     = op_r;
    w_nxt      = w_r;
    row_nxt    = row_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_addr   = set_r;
    seen_start = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        row_nxt  = '0;
        clr_nxt  = clr_r + 1'b1;
        if (32'(clr_r) == NSETS - 1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          set_nxt   = SW'(blk_c & set_mask);
          tag_nxt   = blk_c >> ib_c;
          block_nxt = blk_c;
          op_nxt    = in_data.op;
          w_nxt     = '0;
          mem_addr  = set_nxt;
          st_nxt    = S_READ;
        end
      end
      S_READ: begin
        row_nxt = rd_q;
        st_nxt  = S_CMP;
      end
      S_CMP: begin
        if (line_c[LW-1] && line_c[31:0] == tag_r) begin
          if (op_r) begin
            row_nxt[32'(w_r) * LW + 32] = 1'b1;
            mem_we = 1'b1;
          end
          res_nxt = '{outcome: OUT_HIT, write_back: 1'b0, fill_read: 1'b0,
                      seen_full: 1'b0};
          st_nxt  = S_OUT;
        end else if (WCW'(w_r) + WCW'(1) >= ways_eff) begin
          st_nxt = S_UPD;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      S_UPD: begin
        row_nxt[32'(vic_c) * LW +: LW] = {1'b1, op_r, tag_r};
        row_nxt[RW-1 -: WW] = nxt_c;
        mem_we  = 1'b1;
        res_nxt = '{outcome: OUT_MISS, write_back: vline_c[LW-1] & vline_c[32],
                    fill_read: 1'b1, seen_full: 1'b0};
        if (classify_r) begin
          seen_start = 1'b1;
          st_nxt     = S_SEEN;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_SEEN: begin
        if (seen_done) begin
          res_nxt.outcome   = seen_new ? OUT_COMPULSORY : OUT_MISS;
          res_nxt.seen_full = seen_fl;
          st_nxt            = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
    set_r   <= set_nxt;
    tag_r   <= tag_nxt;
    block_r <= block_nxt;
    op_r    <= op_nxt;
    w_r     <= w_nxt;
    row_r   <= row_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;
endmodule
`default_nettype wire

// ===== rtl/fwbc_checker.sv =====
// ----------------------------------------------------------------------------
// fwbc_checker
// Port-level checks for the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fwbc_port_checker
  import fwbc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OUT_HIT |->
      !out_data.write_back && !out_data.fill_read && !out_data.seen_full)
    else $error("hit with miss flags");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome != OUT_HIT |-> out_data.fill_read)
    else $error("miss without fill");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.seen_full |-> out_data.outcome == OUT_COMPULSORY)
    else $error("full flag on non-compulsory");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
endmodule

bind fifo_write_back_cache_lookup fwbc_port_checker u_fwbc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== tb/sv/fwbc_checker.sv =====
// ----------------------------------------------------------------------------
// fwbc_checker
// Watches the lookup, config and result channels of the cache lookup block.
// Keeps its own copy of the tag store, FIFO pointers and seen-block table,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module fwbc_checker
  import fwbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output int         n_hits,
  output int         n_misses,
  output int         n_compulsory,
  output int         n_write_backs
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS  = 1024;
  localparam int WAYS  = 8;
  localparam int DEPTH = 4096;

  logic [31:0] tag_mem   [SETS][WAYS];
  logic        valid_mem [SETS][WAYS];
  logic        dirty_mem [SETS][WAYS];
  logic [2:0]  victim_ptr[SETS];
  logic [31:0] seen_mem  [DEPTH];
  int          seen_cnt;

  logic [3:0] off_bits, idx_bits, ways_reg;
  logic       classify;

  out_item_t expected_q[$];

  function automatic out_item_t lookup_access(logic is_store, logic [31:0] addr);
    out_item_t   res;
    int          ib, nways, set_i, victim, nxt;
    logic [31:0] block, tag;
    logic        found;
    ib    = (idx_bits > 10) ? 10 : idx_bits;
    nways = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : ways_reg);
    block = addr >> off_bits;
    set_i = block & ((32'h1 << ib) - 1);
    tag   = block >> ib;
    res   = '0;
    for (int w = 0; w < nways; w++) begin
      if (valid_mem[set_i][w] && tag_mem[set_i][w] == tag) begin
        if (is_store) dirty_mem[set_i][w] = 1'b1;
        res.outcome = OUT_HIT;
        return res;
      end
    end
    victim = victim_ptr[set_i];
    if (victim >= nways) victim = 0;
    res.write_back = valid_mem[set_i][victim] && dirty_mem[set_i][victim];
    tag_mem[set_i][victim]   = tag;
    dirty_mem[set_i][victim] = is_store;
    valid_mem[set_i][victim] = 1'b1;
    nxt = victim + 1;
    if (nxt >= nways) nxt = 0;
    victim_ptr[set_i] = nxt[2:0];
    res.fill_read = 1'b1;
    res.outcome   = OUT_MISS;
    if (classify) begin
      found = 1'b0;
      for (int i = 0; i < seen_cnt; i++) begin
        if (seen_mem[i] == block) found = 1'b1;
      end
      if (!found) begin
        res.outcome = OUT_COMPULSORY;
        if (seen_cnt < DEPTH) begin
          seen_mem[seen_cnt] = block;
          seen_cnt++;
        end else begin
          res.seen_full = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        victim_ptr[s] = '0;
        for (int w = 0; w < WAYS; w++) begin
          tag_mem[s][w]   = '0;
          valid_mem[s][w] = 1'b0;
          dirty_mem[s][w] = 1'b0;
        end
      end
      seen_cnt = 0;
      off_bits = 4'd5;
      idx_bits = 4'd10;
      ways_reg = 4'd1;
      classify = 1'b1;
      expected_q.delete();
      errors        <= 0;
      n_hits        <= 0;
      n_misses      <= 0;
      n_compulsory  <= 0;
      n_write_backs <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET:   off_bits = cfg_wdata;
          CFG_INDEX:    idx_bits = cfg_wdata;
          CFG_WAYS:     ways_reg = cfg_wdata;
          CFG_CLASSIFY: classify = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        exp_item = lookup_access(in_data.op, in_data.address);
        expected_q.push_back(exp_item);
        if (exp_item.outcome == OUT_HIT) n_hits <= n_hits + 1;
        else if (exp_item.outcome == OUT_MISS) n_misses <= n_misses + 1;
        else n_compulsory <= n_compulsory + 1;
        if (exp_item.write_back) n_write_backs <= n_write_backs + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.outcome !== exp_item.outcome ||
              out_data.write_back !== exp_item.write_back ||
              out_data.fill_read !== exp_item.fill_read ||
              out_data.seen_full !== exp_item.seen_full) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_item, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives loads and stores through several cache geometries and stall
// patterns; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import fwbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  in_item_t   in_data;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_wdata;
  int         errors, pending, n_hits, n_misses, n_compulsory, n_write_backs;

  int          sent_cnt;
  int          burst_left;
  int          idle_cycles;
  logic [31:0] pool[40];
  logic [3:0]  cur_off;
  logic        cur_classify;

  fifo_write_back_cache_lookup uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  fwbc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .n_hits(n_hits), .n_misses(n_misses),
    .n_compulsory(n_compulsory), .n_write_backs(n_write_backs)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stall patterns, one long hold-off
  initial begin
    int mode, hold_cnt, cyc;
    logic held;
    mode = 0; hold_cnt = 0; cyc = 0; held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (!held && sent_cnt >= 700) begin
        hold_cnt = 400;
        held = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send(logic is_store, logic [31:0] addr, logic last);
    in_valid <= 1'b1;
    in_data  <= '{op: is_store, address: addr};
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    burst_left--;
    if (last || burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
  endtask

  task automatic set_geometry(logic [3:0] o, logic [3:0] i, logic [3:0] w, logic c);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_OFFSET; cfg_wdata <= o;
    @(posedge clk);
    cfg_index <= CFG_INDEX; cfg_wdata <= i;
    @(posedge clk);
    cfg_index <= CFG_WAYS; cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_CLASSIFY; cfg_wdata <= {3'b0, c};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_off = o;
    cur_classify = c;
    foreach (pool[k]) pool[k] = $urandom;
  endtask

  // mostly a small block pool for reuse; full random only when unclassified
  task automatic run_random(int n);
    logic [31:0] addr, mask;
    for (int k = 0; k < n; k++) begin
      mask = (32'h1 << cur_off) - 1;
      if (cur_classify || $urandom_range(0, 4) != 0)
        addr = (pool[$urandom_range(0, 39)] & ~mask) | ($urandom & mask);
      else
        addr = $urandom;
      send(1'($urandom_range(0, 1)), addr, k == n - 1);
    end
  endtask

  initial begin
    rst_n <= 1'b0; in_valid <= 1'b0; in_data <= '0;
    cfg_we <= 1'b0; cfg_index <= CFG_OFFSET; cfg_wdata <= '0;
    sent_cnt = 0; burst_left = 8;
    cur_off = 4'd5; cur_classify = 1'b1;
    foreach (pool[k]) pool[k] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset geometry: 32-byte lines, 1024 sets, direct mapped
    send(1'b0, 32'h0000_0000, 1'b0);
    send(1'b1, 32'h0000_001F, 1'b0);
    send(1'b0, 32'hFFFF_FFFF, 1'b0);
    send(1'b1, 32'hFFFF_FFE0, 1'b0);
    send(1'b0, 32'h0000_8000, 1'b0);
    send(1'b0, 32'h0000_0004, 1'b0);
    send(1'b1, 32'h7FFF_FFFF, 1'b0);
    send(1'b0, 32'h8000_0000, 1'b0);
    send(1'b0, 32'h0000_0000, 1'b0);
    send(1'b1, 32'hAAAA_AAAA, 1'b0);
    send(1'b0, 32'h5555_5555, 1'b1);
    run_random(150);

    set_geometry(4'd0, 4'd0, 4'd8, 1'b1);
    run_random(250);
    set_geometry(4'd12, 4'd3, 4'd8, 1'b0);
    run_random(250);
    set_geometry(4'd12, 4'd3, 4'd3, 1'b0);
    run_random(200);
    set_geometry(4'd15, 4'd15, 4'd0, 1'b1);
    run_random(150);
    set_geometry(4'd4, 4'd2, 4'd15, 1'b0);
    run_random(200);
    set_geometry(4'd0, 4'd10, 4'd1, 1'b0);
    run_random(150);
    set_geometry(4'd2, 4'd4, 4'd5, 1'b1);
    run_random(200);

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d lookups over 8 geometries: %0d hits, %0d misses, %0d compulsory",
             sent_cnt, n_hits, n_misses, n_compulsory);
    $display("Dirty evictions seen: %0d, with random stalls and one long hold-off",
             n_write_backs);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
